>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ilt_pkg.sv
// Types, command and status codes, and default sizes of the indexed list engine.
package ilt_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_WORD_WIDTH = 32;

  localparam logic [2:0] CMD_GET     = 3'd0;
  localparam logic [2:0] CMD_SET     = 3'd1;
  localparam logic [2:0] CMD_SEARCH  = 3'd2;
  localparam logic [2:0] CMD_INSERT  = 3'd3;
  localparam logic [2:0] CMD_APPEND  = 3'd4;
  localparam logic [2:0] CMD_REMOVE  = 3'd5;
  localparam logic [2:0] CMD_CLEAR   = 3'd6;
  localparam logic [2:0] CMD_REVERSE = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOB  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic        found;
    logic [3:0]  found_position;
    logic [4:0]  count;
    logic        empty_res;
  } res_t;

endpackage

>>> design/indexed_list_table_engine_top.sv
// Top level of the indexed list engine: sequencer, element count and result register.
//
// The block keeps an ordered list of up to CAPACITY words in a single-port-write,
// single-port-read RAM and serves one command at a time: get, set, search, insert at
// a position, append, remove at a position, clear and reverse. A command beat is taken
// at a rising edge where start is high and busy is low. Every command gives exactly one
// result beat, shown on the result port while done is high for one cycle; the receiver
// cannot stall it, so it must take the beat in that cycle. The whole rate is set by the
// RAM, which does one read and one write per cycle. After the command is taken, busy
// stays high while get, set, search (one element a cycle, up to the first match),
// insert, remove or reverse (S_REV_A, S_REV_B, S_REV_C for each swapped pair) runs;
// append, clear, removing the last element, searching an empty list, reversing under
// two elements and failed commands never raise it. The result beat comes in the first
// cycle in which busy is low again, or in the cycle after acceptance when busy never
// rises; busy is low in that cycle, so the next command may be taken then. Failed
// commands (position out of bounds, list full) leave the list untouched and report
// zero data. The RAM needs no clearing after reset: only positions below the count
// are ever read, and each of them has been written.
module indexed_list_table_engine_top #(
  parameter int CAPACITY   = ilt_pkg::DEF_CAPACITY,
  parameter int WORD_WIDTH = ilt_pkg::DEF_WORD_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ilt_pkg::req_t request,
  output logic          done,
  output ilt_pkg::res_t result
);

  import ilt_pkg::*;

  // Widths: an element address, the element count, and a comparison width that also
  // holds the 5-bit command position with a spare bit for sums.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int XW    = ((CNT_W > 5) ? CNT_W : 5) + 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_GET     = 4'd1;
  localparam logic [3:0] S_SET     = 4'd2;
  localparam logic [3:0] S_SRCH    = 4'd3;
  localparam logic [3:0] S_SHIFT_R = 4'd4;
  localparam logic [3:0] S_INS_PUT = 4'd5;
  localparam logic [3:0] S_SHIFT_L = 4'd6;
  localparam logic [3:0] S_REV_A   = 4'd7;
  localparam logic [3:0] S_REV_B   = 4'd8;
  localparam logic [3:0] S_REV_C   = 4'd9;

  logic [3:0]            state, state_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [IDX_W-1:0]      hi, hi_next;
  logic [IDX_W-1:0]      pos_q, pos_q_next;
  logic [WORD_WIDTH-1:0] val_q, val_q_next;
  logic [WORD_WIDTH-1:0] tmp, tmp_next;
  logic [CNT_W-1:0]      count, count_next;

  // RAM port controls.
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [WORD_WIDTH-1:0] wr_data, rd_data;

  // Result fields for the command that finishes in this cycle.
  logic                  finish;
  logic [1:0]            status_f;
  logic [31:0]           data_f;
  logic                  found_f;
  logic [3:0]            fpos_f;

  logic [XW-1:0]         pos_x, cnt_x;
  logic                  full;

  assign pos_x = XW'(request.position);
  assign cnt_x = XW'(count);
  assign full  = (count == CNT_W'(CAPACITY));
  assign busy  = (state != S_IDLE);

  ilt_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The sequencer. Shifts overlap the read of the next element with the write of the
  // current one and searches with the compare, so both move one element per cycle; a
  // reverse swap runs S_REV_A, S_REV_B, S_REV_C: both ends are read before any write.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    hi_next    = hi;
    pos_q_next = pos_q;
    val_q_next = val_q;
    tmp_next   = tmp;
    count_next = count;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    finish     = 1'b0;
    status_f   = ST_OK;
    data_f     = '0;
    found_f    = 1'b0;
    fpos_f     = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          pos_q_next = IDX_W'(request.position);
          val_q_next = WORD_WIDTH'(request.value);
          unique case (request.command) inside
            CMD_GET, CMD_SET: begin
              if (pos_x < cnt_x) begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(request.position);
                state_next = (request.command == CMD_GET) ? S_GET : S_SET;
              end else begin
                status_f = ST_OOB;
                finish   = 1'b1;
              end
            end
            CMD_SEARCH: begin
              if (count == '0) begin
                finish = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = S_SRCH;
              end
            end
            CMD_INSERT: begin
              if (pos_x > cnt_x) begin
                status_f = ST_OOB;
                finish   = 1'b1;
              end else if (full) begin
                status_f = ST_FULL;
                finish   = 1'b1;
              end else begin
                // Shift from the old last element down to the insert position.
                idx_next = IDX_W'(count);
                if (pos_x == cnt_x) begin
                  state_next = S_INS_PUT;
                end else begin
                  rd_en      = 1'b1;
                  rd_addr    = IDX_W'(count) - IDX_W'(1);
                  state_next = S_SHIFT_R;
                end
              end
            end
            CMD_APPEND: begin
              if (full) begin
                status_f = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(count);
                wr_data    = WORD_WIDTH'(request.value);
                count_next = count + CNT_W'(1);
              end
              finish = 1'b1;
            end
            CMD_REMOVE: begin
              if (pos_x < cnt_x) begin
                idx_next = IDX_W'(request.position);
                if (pos_x + XW'(1) >= cnt_x) begin
                  count_next = count - CNT_W'(1);
                  finish     = 1'b1;
                end else begin
                  rd_en      = 1'b1;
                  rd_addr    = IDX_W'(request.position) + IDX_W'(1);
                  state_next = S_SHIFT_L;
                end
              end else begin
                status_f = ST_OOB;
                finish   = 1'b1;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
              finish     = 1'b1;
            end
            CMD_REVERSE: begin
              if (count < CNT_W'(2)) begin
                finish = 1'b1;
              end else begin
                idx_next   = '0;
                hi_next    = IDX_W'(count - CNT_W'(1));
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_REV_A;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_GET: begin
        data_f = 32'(rd_data);
        finish = 1'b1;
      end

      S_SET: begin
        data_f  = 32'(rd_data);
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = val_q;
        finish  = 1'b1;
      end

      S_SRCH: begin
        if (rd_data == val_q) begin
          found_f = 1'b1;
          fpos_f  = 4'(idx);
          finish  = 1'b1;
        end else if (XW'(idx) + XW'(1) < cnt_x) begin
          rd_en    = 1'b1;
          rd_addr  = idx + IDX_W'(1);
          idx_next = idx + IDX_W'(1);
        end else begin
          finish = 1'b1;
        end
      end

      S_SHIFT_R: begin
        wr_en    = 1'b1;
        wr_addr  = idx;
        wr_data  = rd_data;
        idx_next = idx - IDX_W'(1);
        if (idx - IDX_W'(1) == pos_q) begin
          state_next = S_INS_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx - IDX_W'(2);
        end
      end

      S_INS_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = pos_q;
        wr_data    = val_q;
        count_next = count + CNT_W'(1);
        finish     = 1'b1;
      end

      S_SHIFT_L: begin
        wr_en    = 1'b1;
        wr_addr  = idx;
        wr_data  = rd_data;
        idx_next = idx + IDX_W'(1);
        if (XW'(idx) + XW'(2) < cnt_x) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(XW'(idx) + XW'(2));
        end else begin
          count_next = count - CNT_W'(1);
          finish     = 1'b1;
        end
      end

      S_REV_A: begin
        tmp_next   = rd_data;
        rd_en      = 1'b1;
        rd_addr    = hi;
        state_next = S_REV_B;
      end

      S_REV_B: begin
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_data    = rd_data;
        state_next = S_REV_C;
      end

      S_REV_C: begin
        wr_en    = 1'b1;
        wr_addr  = hi;
        wr_data  = tmp;
        idx_next = idx + IDX_W'(1);
        hi_next  = hi - IDX_W'(1);
        if (idx + IDX_W'(1) < hi - IDX_W'(1)) begin
          rd_en      = 1'b1;
          rd_addr    = idx + IDX_W'(1);
          state_next = S_REV_A;
        end else begin
          finish = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = S_IDLE;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
  end

  // Working registers and the result beat.
  always_ff @(posedge clk) begin
    idx   <= idx_next;
    hi    <= hi_next;
    pos_q <= pos_q_next;
    val_q <= val_q_next;
    tmp   <= tmp_next;
    if (finish) begin
      result.status         <= status_f;
      result.data           <= data_f;
      result.found          <= found_f;
      result.found_position <= fpos_f;
      result.count          <= 5'(count_next);
      result.empty_res      <= (count_next == '0);
    end
  end

endmodule

>>> design/ilt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ilt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/ilt_checker.sv
// Port-level checker for the indexed list engine, bound to its top level.
`include "assert_macros.svh"

module ilt_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ilt_pkg::res_t result
);

  import ilt_pkg::*;

  // A result beat is only ever shown while the engine is ready for the next command.
  `ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy, "result beat while busy")

  // An accepted command either finishes at once or keeps the engine busy.
  `ASSERT_NXT(a_accept_progress, clk, rst, start && !busy, done || busy,
              "accepted command neither finished nor started work")

  // Leaving a busy stretch always delivers its result.
  `ASSERT_IMP(a_busy_ends_done, clk, rst, !$past(rst) && $fell(busy), done,
              "busy fell without a result beat")

  // The empty flag agrees with the reported count.
  `ASSERT_IMP(a_empty_count, clk, rst, done, result.empty_res == (result.count == 5'd0),
              "empty flag disagrees with count")

  // A failed command reports no data and no match.
  `ASSERT_IMP(a_error_clean, clk, rst, done && (result.status != ST_OK),
              (result.data == 32'd0) && !result.found, "failed command reported data")

endmodule

bind indexed_list_table_engine_top ilt_checker u_ilt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
